### rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared widths, register map, reset values and control structs of the
// constant fraction hit timing block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int FRAC_W    = 9;
    localparam int DELAY_W   = 4;
    localparam int THR_W     = 12;
    localparam int BASE_W    = 12;
    localparam int TIME_W    = 10;

    // Datapath widths: sample minus baseline, CFD value, divider operands
    localparam int DIFF_W    = 13;
    localparam int CFD_W     = 23;
    localparam int DEN_W     = 24;

    // Divider: one quotient bit per step
    localparam int FINE_BITS = 10;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FINE_BITS - 1);

    // APB port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_FRACTION  = 2'd0;
    localparam logic [1:0] REG_DELAY     = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_BASELINE  = 2'd3;

    // Reset values
    localparam logic [FRAC_W-1:0]  FRACTION_RST  = 9'd154;
    localparam logic [DELAY_W-1:0] DELAY_RST     = 4'd1;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 12'd20;
    localparam logic [BASE_W-1:0]  BASELINE_RST  = 12'd200;

    typedef struct packed {
        logic [FRAC_W-1:0]  fraction;
        logic [DELAY_W-1:0] delay;
        logic [THR_W-1:0]   threshold;
        logic [BASE_W-1:0]  baseline;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic eval;
        logic div_step;
        logic put;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit_norm;
        logic hit_zero;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

### rtl/cfd_regs.sv
// ----------------------------------------------------------------------------
// cfd_regs
// APB configuration registers: fraction, delay, threshold and baseline.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cfd_pkg::PADDR_W-1:0]    paddr,
    input  logic [cfd_pkg::PDATA_W-1:0]    pwdata,
    output logic [cfd_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output cfd_pkg::cfg_t                  cfg
);
    import cfd_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Write the addressed register in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fraction  <= FRACTION_RST;
            cfg_reg.delay     <= DELAY_RST;
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.baseline  <= BASELINE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRACTION:  cfg_reg.fraction  <= pwdata[FRAC_W-1:0];
                REG_DELAY:     cfg_reg.delay     <= pwdata[DELAY_W-1:0];
                REG_THRESHOLD: cfg_reg.threshold <= pwdata[THR_W-1:0];
                REG_BASELINE:  cfg_reg.baseline  <= pwdata[BASE_W-1:0];
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_FRACTION:  prdata = PDATA_W'(cfg_reg.fraction);
            REG_DELAY:     prdata = PDATA_W'(cfg_reg.delay);
            REG_THRESHOLD: prdata = PDATA_W'(cfg_reg.threshold);
            REG_BASELINE:  prdata = PDATA_W'(cfg_reg.baseline);
        endcase
    end

endmodule

`default_nettype wire

### rtl/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// cfd_ctrl
// Sequencer: takes one sample, steps it through multiply and evaluate and,
// on a hit, through divide (ordinary hits only) and output hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cfd_pkg::sts_t   sts,
    output cfd_pkg::cmd_t   cmd
);
    import cfd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    // Issue commands for the current state
    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_valid && in_ready;
        cmd.mul      = (state_reg == S_MUL);
        cmd.eval     = (state_reg == S_EVAL);
        cmd.div_step = (state_reg == S_DIV);
        cmd.put      = (state_reg == S_PUT) && !sts.out_busy;
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cnt_next = '0;
                priority if (sts.hit_norm)
                    state_next = S_DIV;
                else if (sts.hit_zero)
                    state_next = S_PUT;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                if (!sts.out_busy)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cfd_dp.sv
// ----------------------------------------------------------------------------
// cfd_dp
// Datapath: sample delay line, CFD product and difference, crossing tests,
// restoring divider for the fine time and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_dp #(
    parameter int MAX_DELAY     = 15,
    parameter int FRAME_SAMPLES = 1024,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfd_pkg::cfg_t                  cfg,
    input  cfd_pkg::cmd_t                  cmd,
    output cfd_pkg::sts_t                  sts,
    input  logic [cfd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                           frame_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cfd_pkg::TIME_W-1:0]     frame_time,
    output logic [cfd_pkg::TIME_W-1:0]     fine_time
);
    import cfd_pkg::*;

    localparam int DW = $clog2(MAX_DELAY + 1);
    localparam int IW = $clog2(FRAME_SAMPLES + 1);
    localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [DW-1:0]       DMAX  = DW'(MAX_DELAY);
    localparam logic [IW-1:0]       ILIM  = IW'(FRAME_SAMPLES);

    // Delay line and taps
    logic [SAMPLE_W-1:0]      hist_reg [MAX_DELAY];
    logic [SAMPLE_W-1:0]      taps     [MAX_DELAY+1];
    logic [SAMPLE_W-1:0]      s_m;
    logic [DW-1:0]            d_sat;

    // Per-sample registers
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            idx_next;
    logic [IW-1:0]            idx_hold_reg;
    logic [DW-1:0]            d_hold_reg;
    logic signed [DIFF_W-1:0] sdiff_reg;
    logic signed [DIFF_W-1:0] ddiff_reg;
    logic signed [CFD_W-1:0]  prod_next;
    logic signed [CFD_W-1:0]  prod_reg;
    logic [CFD_W-1:0]         prev_reg;
    logic [CFD_W-1:0]         prev2_reg;

    // Evaluation
    logic [DEN_W-1:0]         cur_w;
    logic [DEN_W-1:0]         neg_cur;
    logic [DEN_W-1:0]         thr_w;
    logic [DEN_W-1:0]         m_w;
    logic [DEN_W-1:0]         k_w;
    logic                     win;
    logic                     m_pos;
    logic                     m_zero;
    logic                     k_pos;
    logic                     cur_neg;
    logic                     cur_big;

    // Divider
    logic [DEN_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         rem_next;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W:0]           rem_x2;
    logic                     q_bit;
    logic [FINE_BITS-1:0]     q_reg;
    logic [TIME_W-1:0]        ft_reg;

    // Output register
    logic                     out_valid_reg;
    logic [TIME_W-1:0]        frame_time_reg;
    logic [TIME_W-1:0]        fine_time_reg;

    // Mask the sample and saturate the delay
    always_comb
    begin
        s_m   = sample & SMASK;
        d_sat = (int'(cfg.delay) > MAX_DELAY) ? DMAX : DW'(cfg.delay);
    end

    // Tap zero is the incoming sample, tap j the sample j steps back
    always_comb
    begin
        taps[0] = s_m;
        for (int j = 1; j <= MAX_DELAY; j++)
            taps[j] = hist_reg[j-1];
    end

    // Clear the delay line on reset, shift it on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_DELAY; j++)
                hist_reg[j] <= '0;
        end
        else if (cmd.load)
        begin
            hist_reg[0] <= s_m;
            for (int j = 1; j < MAX_DELAY; j++)
                hist_reg[j] <= hist_reg[j-1];
        end
    end

    // Frame index: restart on the last sample, hold at the frame length
    always_comb
    begin
        priority if (frame_last)
            idx_next = '0;
        else if (idx_reg < ILIM)
            idx_next = idx_reg + 1'b1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.load)
            idx_reg <= idx_next;
    end

    // Capture baseline-corrected samples, index and delay of this item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sdiff_reg    <= $signed({1'b0, s_m}) - $signed({1'b0, cfg.baseline});
            ddiff_reg    <= $signed({1'b0, taps[d_sat]}) - $signed({1'b0, cfg.baseline});
            idx_hold_reg <= idx_reg;
            d_hold_reg   <= d_sat;
        end
    end

    // Attenuated copy: fraction times corrected sample
    assign prod_next = $signed({1'b0, cfg.fraction}) * sdiff_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= prod_next;
    end

    // CFD value and crossing tests
    always_comb
    begin
        cur_w   = {prod_reg[CFD_W-1], prod_reg}
                - {{3{ddiff_reg[DIFF_W-1]}}, ddiff_reg, 8'd0};
        neg_cur = DEN_W'(0) - cur_w;
        thr_w   = DEN_W'({cfg.threshold, 8'd0});
        m_w     = DEN_W'(prev_reg);
        k_w     = DEN_W'(prev2_reg);
        win     = (int'(idx_hold_reg) < FRAME_SAMPLES)
               && (int'(idx_hold_reg) >= int'(d_hold_reg) + 3);
        m_zero  = (prev_reg == '0);
        m_pos   = !prev_reg[CFD_W-1] && !m_zero;
        k_pos   = !prev2_reg[CFD_W-1] && (prev2_reg != '0);
        cur_neg = cur_w[DEN_W-1];
        cur_big = neg_cur > thr_w;

        sts.hit_norm = win && m_pos && cur_neg && ((m_w > thr_w) || cur_big);
        sts.hit_zero = win && m_zero && k_pos && cur_neg && ((k_w > thr_w) || cur_big);
        sts.out_busy = out_valid_reg && !out_ready;
    end

    // Keep the two previous CFD values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            prev2_reg <= '0;
        end
        else if (cmd.eval)
        begin
            prev2_reg <= prev_reg;
            prev_reg  <= cur_w[CFD_W-1:0];
        end
    end

    // Restoring division step: one quotient bit of 1024*m/(m-n)
    always_comb
    begin
        rem_x2   = {rem_reg, 1'b0};
        q_bit    = rem_x2 >= {1'b0, den_reg};
        rem_next = q_bit ? DEN_W'(rem_x2 - {1'b0, den_reg}) : rem_x2[DEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            rem_reg <= m_w;
            den_reg <= m_w + neg_cur;
            q_reg   <= '0;
            ft_reg  <= TIME_W'(idx_hold_reg - IW'(1));
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[FINE_BITS-2:0], q_bit};
        end
    end

    // Result register: load on hand-off, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.put)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            frame_time_reg <= ft_reg;
            fine_time_reg  <= TIME_W'(q_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_time = frame_time_reg;
    assign fine_time  = fine_time_reg;

endmodule

`default_nettype wire

### rtl/cfd_hit_timing.sv
// ----------------------------------------------------------------------------
// cfd_hit_timing
// Digital constant fraction discriminator: finds positive-to-negative zero
// crossings of the CFD signal in framed ADC data and reports their timing.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one ADC sample per request with
//   frame_last marking the last sample of a frame. Output channel
//   (out_valid/out_ready) delivers one request per hit: frame_time, the frame
//   index before the crossing, and fine_time in 1/1024 sample units.
//   Configuration (fraction, delay, threshold, baseline) is written over the
//   APB port while no sample is in flight.
// Sequence:
//   A sample without a hit passes through capture, multiply and evaluate.
//   A hit through zero adds the output hand-off, an ordinary hit also the
//   divide steps: a restoring divider yields the fine time, one quotient bit
//   per cycle. A result is loaded into the output register in the hand-off
//   state, which follows multiply, evaluate and, for an ordinary hit, divide.
//   in_ready is high again as soon as the result sits in the output register;
//   a stalled receiver holds the block only when a further hit is ready to be
//   handed over.
// Reset: rst_n clears the frame index, the sample delay line, the previous
//   CFD values, the output valid and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_hit_timing #(
    parameter int MAX_DELAY     = 15,
    parameter int FRAME_SAMPLES = 1024,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cfd_pkg::PADDR_W-1:0]    paddr,
    input  logic [cfd_pkg::PDATA_W-1:0]    pwdata,
    output logic [cfd_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cfd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                           frame_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cfd_pkg::TIME_W-1:0]     frame_time,
    output logic [cfd_pkg::TIME_W-1:0]     fine_time
);
    import cfd_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    cfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfd_dp #(
        .MAX_DELAY     (MAX_DELAY),
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .sample     (sample),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_time (frame_time),
        .fine_time  (fine_time)
    );

endmodule

`default_nettype wire

### rtl/cfd_checker.sv
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks of the hit timing block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [cfd_pkg::TIME_W-1:0]     frame_time,
    input  logic [cfd_pkg::TIME_W-1:0]     fine_time
);

    // One sample at a time: ready drops after each request
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after a sample request");

    // A fresh result is handed over only while a sample is being worked on
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a sample in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_time) && $stable(fine_time))
        else $error("stalled result changed");

    // With no result pending, none reaches the port while a new sample is in multiply and evaluate
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
        else $error("result came too early after a sample request");

endmodule

bind cfd_hit_timing cfd_checker u_cfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_time (frame_time),
    .fine_time  (fine_time)
);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for cfd_hit_timing. An in-bench predictor replays every
// accepted sample and queues the hits it should produce. Each hit handed out
// by the block is compared field by field with the oldest queued hit.
// Directed frames run first: register defaults, the extremes, a normal
// crossing, a crossing through zero, a crossing that comes too early in the
// frame, a register change inside a frame and frame index saturation.
// Random pulse frames follow under several register settings. Requests
// arrive in bursts, with random gaps outside steady phases, and the
// receiver stalls in its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import cfd_pkg::*;

    localparam int MAX_DELAY     = 15;
    localparam int FRAME_SAMPLES = 1024;
    localparam int SAMPLE_BITS   = 12;
    localparam int HIST_DEPTH    = MAX_DELAY + 3;

    typedef struct {
        logic [TIME_W-1:0] coarse;
        logic [TIME_W-1:0] fine;
    } hit_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample     = '0;
    logic                frame_last = 1'b0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [TIME_W-1:0]   frame_time;
    logic [TIME_W-1:0]   fine_time;

    // Predictor state and its copy of the registers
    logic [FRAC_W-1:0]   frac_cfg = FRACTION_RST;
    logic [DELAY_W-1:0]  dly_cfg  = DELAY_RST;
    logic [THR_W-1:0]    thr_cfg  = THRESHOLD_RST;
    logic [BASE_W-1:0]   base_cfg = BASELINE_RST;
    logic [SAMPLE_W-1:0] sample_hist [0:HIST_DEPTH-1] = '{default: '0};
    int                  cfd_m1    = 0;
    int                  cfd_m2    = 0;
    int                  frame_idx = 0;

    hit_t pending_hits [$];
    int   errors     = 0;
    int   sent_count = 0;
    int   burst_left = 0;
    bit   steady     = 1'b0;

    cfd_hit_timing #(
        .MAX_DELAY     (MAX_DELAY),
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_time (frame_time),
        .fine_time  (fine_time)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the CFD state by one sample and queue the hit it gives, if any
    task automatic predict_cfd_hit(input logic [SAMPLE_W-1:0] s, input logic last);
        int     j;
        int     d;
        int     cur;
        int     t;
        longint num;
        longint den;
        hit_t   h;
        for (j = HIST_DEPTH - 1; j > 0; j--)
            sample_hist[j] = sample_hist[j-1];
        sample_hist[0] = s;
        d   = (int'(dly_cfg) > MAX_DELAY) ? MAX_DELAY : int'(dly_cfg);
        cur = int'(frac_cfg) * (int'(s) - int'(base_cfg))
            - 256 * (int'(sample_hist[d]) - int'(base_cfg));
        t   = 256 * int'(thr_cfg);
        if (frame_idx < FRAME_SAMPLES && frame_idx >= d + 3)
        begin
            if (cfd_m1 > 0 && cur < 0 && (cfd_m1 > t || cur < -t))
            begin
                num      = 1024 * longint'(cfd_m1);
                den      = longint'(cfd_m1) - longint'(cur);
                h.coarse = TIME_W'(frame_idx - 1);
                h.fine   = TIME_W'(num / den);
                pending_hits.insert(pending_hits.size(), h);
            end
            else if (cfd_m1 == 0 && cfd_m2 > 0 && cur < 0 && (cfd_m2 > t || cur < -t))
            begin
                h.coarse = TIME_W'(frame_idx - 1);
                h.fine   = '0;
                pending_hits.insert(pending_hits.size(), h);
            end
        end
        cfd_m2 = cfd_m1;
        cfd_m1 = cur;
        if (last)
            frame_idx = 0;
        else if (frame_idx < FRAME_SAMPLES)
            frame_idx++;
    endtask

    // Write one register over APB, then leave the bus idle before returning
    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRACTION:  frac_cfg = FRAC_W'(val);
            REG_DELAY:     dly_cfg  = DELAY_W'(val);
            REG_THRESHOLD: thr_cfg  = THR_W'(val);
            REG_BASELINE:  base_cfg = BASE_W'(val);
            default:       ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input int f, input int d, input int t, input int b);
        write_reg(REG_FRACTION, f);
        write_reg(REG_DELAY, d);
        write_reg(REG_THRESHOLD, t);
        write_reg(REG_BASELINE, b);
    endtask

    // Send one sample request; open a new burst after a random gap when due
    task automatic send_sample(input int lvl, input bit last);
        int                  gap;
        logic [SAMPLE_W-1:0] s;
        s = (lvl < 0) ? '0 : (lvl > 4095) ? SAMPLE_W'(4095) : SAMPLE_W'(lvl);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = steady ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        sample     <= s;
        frame_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_cfd_hit(s, last);
        sent_count++;
    endtask

    // Drop valid, let every queued hit come out, then let the pipeline empty
    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_flat(input int lvl, input int count, input bit last_at_end);
        int j;
        for (j = 0; j < count; j++)
            send_sample(lvl + int'($urandom_range(0, 6)) - 3, last_at_end && j == count - 1);
    endtask

    // Triangular pulse; cut_at marks the sample that ends the frame early
    task automatic send_pulse(input int ped, input int amp, input int rise, input int fall,
                              input int cut_at);
        int j;
        int n;
        n = rise + fall;
        for (j = 1; j <= n; j++)
            send_sample((j <= rise) ? ped + amp * j / rise : ped + amp * (n - j) / fall,
                        j == cut_at);
    endtask

    task automatic send_random_frame();
        int kind;
        int ped;
        int amp;
        int rise;
        int fall;
        int j;
        int len;
        kind = $urandom_range(0, 99);
        ped  = int'(base_cfg) + int'($urandom_range(0, 8)) - 4;
        amp  = $urandom_range(0, 1) ? int'($urandom_range(20, 4095))
                                    : int'($urandom_range(0, 200));
        rise = $urandom_range(1, 4);
        fall = $urandom_range(1, 12);
        // invert pulses that have no headroom above a high pedestal
        if (ped > 2047)
            amp = -amp;
        if (kind < 80)
        begin
            send_flat(ped, $urandom_range(1, 20), 1'b0);
            send_pulse(ped, amp, rise, fall, 0);
            if (kind < 15)
                send_pulse(ped + amp / 3, amp / 2, $urandom_range(1, 3),
                           $urandom_range(2, 10), 0);
            send_flat(ped, $urandom_range(1, 12), 1'b1);
        end
        else if (kind < 90)
        begin
            len = $urandom_range(1, 20);
            for (j = 0; j < len; j++)
                send_sample($urandom_range(0, 4095), j == len - 1);
        end
        else
        begin
            send_flat(ped, $urandom_range(0, 10), 1'b0);
            send_pulse(ped, amp, rise, fall, $urandom_range(1, rise + fall));
        end
    endtask

    // Register defaults: flat baseline then a step, crossing between indexes 4 and 5
    task automatic test_reset_config();
        send_flat(200, 4, 1'b0);
        send_sample(1200, 1'b0);
        send_sample(1200, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed_cases();
        set_config(128, 1, 0, 0);
        // ramp that lands exactly on zero before turning negative
        send_flat(0, 0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(100, 1'b0);
        send_sample(200, 1'b0);
        send_sample(200, 1'b0);
        // full-scale step, normal crossing
        send_sample(4095, 1'b0);
        send_sample(4095, 1'b0);
        send_sample(0, 1'b1);
        // crossing too early in the frame
        send_sample(0, 1'b0);
        send_sample(1000, 1'b0);
        send_sample(1000, 1'b1);
        // fraction changes between the two samples around the crossing
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(1000, 1'b0);
        wait_idle();
        write_reg(REG_FRACTION, 192);
        send_sample(1000, 1'b0);
        send_sample(1000, 1'b1);
        wait_idle();
    endtask

    // One frame well past the frame length, with pulses throughout
    task automatic test_index_saturation();
        int n;
        int ped;
        int rise;
        int fall;
        int flat_len;
        set_config($urandom_range(100, 220), $urandom_range(1, 4), $urandom_range(0, 40),
                   $urandom_range(50, 400));
        steady = 1'b0;
        ped    = int'(base_cfg);
        n      = 0;
        while (n < 1100)
        begin
            flat_len = $urandom_range(8, 20);
            rise     = $urandom_range(1, 4);
            fall     = $urandom_range(2, 10);
            send_flat(ped, flat_len, 1'b0);
            send_pulse(ped, $urandom_range(100, 3500), rise, fall, 0);
            n += flat_len + rise + fall;
        end
        send_flat(ped, 3, 1'b1);
        // index restarts after the frame end
        send_random_frame();
        wait_idle();
    endtask

    task automatic test_random_frames();
        int phase;
        int start;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_config(256, 15, 4095, 4095);
                1:       set_config(0, 0, 0, 0);
                default: set_config($urandom_range(0, 256), $urandom_range(0, 15),
                                    $urandom_range(0, 200), $urandom_range(0, 1000));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            start  = sent_count;
            while (sent_count - start < 150)
                send_random_frame();
            wait_idle();
        end
    endtask

    // Receiver: always ready, coin-flip, or long stalls, switching now and then
    int rdy_mode = 0;
    int rdy_left = 0;
    int mode_left = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rdy_mode  <= $urandom_range(0, 2);
            mode_left <= $urandom_range(100, 400);
        end
        else
            mode_left <= mode_left - 1;
        if (rdy_left != 0)
            rdy_left <= rdy_left - 1;
        else
        begin
            case (rdy_mode)
                0:
                begin
                    out_ready <= 1'b1;
                    rdy_left  <= 8;
                end
                1:
                begin
                    out_ready <= $urandom_range(0, 1);
                    rdy_left  <= 0;
                end
                default:
                begin
                    out_ready <= ~out_ready;
                    rdy_left  <= out_ready ? $urandom_range(1, 20) : $urandom_range(0, 4);
                end
            endcase
        end
    end

    // Compare each handed-over hit with the oldest predicted one
    always @(posedge clk)
    begin : hit_check
        hit_t h;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t unexpected hit: frame_time %0d fine_time %0d",
                         $time, frame_time, fine_time);
                errors++;
            end
            else
            begin
                h = pending_hits.pop_front();
                if (frame_time !== h.coarse)
                begin
                    $display("%0t frame_time mismatch: expected %0d, actual %0d",
                             $time, h.coarse, frame_time);
                    errors++;
                end
                if (fine_time !== h.fine)
                begin
                    $display("%0t fine_time mismatch: expected %0d, actual %0d",
                             $time, h.fine, fine_time);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_directed_cases();
        test_index_saturation();
        test_random_frames();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("cfd_hit_timing regression: pass");
        else
            $display("cfd_hit_timing regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("cfd_hit_timing regression: fail");
        $finish;
    end

endmodule
